// File: rtl/core/i2p_pkg.sv
// Shared types, codes and helpers for the infix-to-postfix converter.
package i2p_pkg;

    // Input token classes
    localparam logic [2:0] CLS_NUMBER = 3'd0;
    localparam logic [2:0] CLS_FUNC   = 3'd1;
    localparam logic [2:0] CLS_OP     = 3'd2;
    localparam logic [2:0] CLS_LPAREN = 3'd3;
    localparam logic [2:0] CLS_RPAREN = 3'd4;
    localparam logic [2:0] CLS_END    = 3'd5;

    // Operator codes
    localparam logic [2:0] OP_PLUS   = 3'd0;
    localparam logic [2:0] OP_MINUS  = 3'd1;
    localparam logic [2:0] OP_TIMES  = 3'd2;
    localparam logic [2:0] OP_DIVIDE = 3'd3;
    localparam logic [2:0] OP_POWER  = 3'd4;

    // Stack entry kinds
    localparam logic [1:0] KIND_FUNC   = 2'd1;
    localparam logic [1:0] KIND_OP     = 2'd2;
    localparam logic [1:0] KIND_LPAREN = 2'd3;

    // Result kinds
    localparam logic [1:0] OUT_NUMBER = 2'd0;
    localparam logic [1:0] OUT_FUNC   = 2'd1;
    localparam logic [1:0] OUT_OP     = 2'd2;
    localparam logic [1:0] OUT_END    = 2'd3;

    // End marker status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int VALUE_W = 64;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] arg;
    } entry_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         op;
        logic [4:0]         func;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        logic   rd;
        logic   clear;
        entry_t data;
    } stack_cmd_t;

    typedef struct packed {
        logic empty;
        logic one;
        logic full;
        logic has_lparen;
    } stack_sts_t;

    function automatic logic [1:0] prec_of(input logic [4:0] op);
        logic [1:0] p;
        p = 2'd0;
        if (op[4:3] == 2'b00) begin
            case (op[2:0]) inside
                OP_PLUS, OP_MINUS:   p = 2'd1;
                OP_TIMES, OP_DIVIDE: p = 2'd2;
                OP_POWER:            p = 2'd3;
                default:             p = 2'd0;
            endcase
        end
        return p;
    endfunction

    function automatic result_t entry_to_result(input entry_t e);
        result_t r;
        r = '0;
        if (e.kind == KIND_FUNC) begin
            r.kind = OUT_FUNC;
            r.func = e.arg;
        end else begin
            r.kind = OUT_OP;
            r.op   = e.arg[2:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/i2p_stack.sv
// Operator stack: single-port memory, fill count and open-paren count.
module i2p_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2p_pkg::stack_cmd_t cmd,
    output i2p_pkg::stack_sts_t sts,
    output i2p_pkg::entry_t     top
);
    import i2p_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    entry_t         mem [STACK_DEPTH];
    entry_t         rd_data_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  lp_reg, lp_next;
    logic [CW-1:0]  rd_cnt;
    logic [IW-1:0]  rd_idx;

    // Read the entry that becomes the top after a pop in the same cycle
    assign rd_cnt = count_reg - (cmd.pop ? CW'(2) : CW'(1));
    assign rd_idx = rd_cnt[IW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[count_reg[IW-1:0]] <= cmd.data;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_comb begin
        count_next = count_reg;
        lp_next    = lp_reg;
        if (cmd.clear) begin
            count_next = '0;
            lp_next    = '0;
        end else if (cmd.push) begin
            count_next = count_reg + CW'(1);
            if (cmd.data.kind == KIND_LPAREN) begin
                lp_next = lp_reg + CW'(1);
            end
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
            if (rd_data_reg.kind == KIND_LPAREN) begin
                lp_next = lp_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            lp_reg    <= '0;
        end else begin
            count_reg <= count_next;
            lp_reg    <= lp_next;
        end
    end

    assign sts.empty      = (count_reg == '0);
    assign sts.one        = (count_reg == CW'(1));
    assign sts.full       = (count_reg == CW'(STACK_DEPTH));
    assign sts.has_lparen = (lp_reg != '0);
    assign top            = rd_data_reg;

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !sts.full) else $error("push into full stack");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !sts.empty) else $error("pop from empty stack");
    a_push_pop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push && cmd.pop)) else $error("push and pop together");
    a_lp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lp_reg <= count_reg) else $error("open-paren count above depth");

endmodule

// File: rtl/core/i2p_ctrl.sv
// Token sequencer: precedence compare, pop loops and held-result release.
module i2p_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_class,
    input  logic [2:0]                s_op,
    input  logic [4:0]                s_func,
    input  logic [i2p_pkg::VALUE_W-1:0] s_value,
    output i2p_pkg::stack_cmd_t       cmd,
    input  i2p_pkg::stack_sts_t       sts,
    input  i2p_pkg::entry_t           top,
    output logic                      out_valid,
    output i2p_pkg::result_t          out_data,
    input  logic                      out_ready
);
    import i2p_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_OP     = 9'b000000100,
        S_PUSH   = 9'b000001000,
        S_RP     = 9'b000010000,
        S_RPF    = 9'b000100000,
        S_END    = 9'b001000000,
        S_MARK   = 9'b010000000,
        S_FLUSH  = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         cls_reg;
    logic [2:0]         op_reg;
    logic [4:0]         func_reg;
    logic [VALUE_W-1:0] value_reg;
    result_t            pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               ovf_reg, ovf_next;

    logic               adv;
    logic               take;
    logic [1:0]         p_in, p_top;
    entry_t             push_entry;
    result_t            top_res, num_res, mark_res;

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cls_reg   <= s_class;
            op_reg    <= s_op;
            func_reg  <= s_func;
            value_reg <= s_value;
        end
        pend_reg <= pend_next;
    end

    // Precedence compare against the current stack top
    assign p_in  = prec_of({2'b00, op_reg});
    assign p_top = prec_of(top.arg);
    assign take  = (top.kind == KIND_FUNC) ||
                   ((top.kind == KIND_OP) &&
                    ((p_top > p_in) || ((p_top == p_in) && (op_reg != OP_POWER))));

    // A new result may be held only once the older one can leave
    assign adv = !pend_valid_reg || out_ready;

    always_comb begin
        push_entry = '0;
        case (cls_reg)
            CLS_FUNC: begin
                push_entry.kind = KIND_FUNC;
                push_entry.arg  = func_reg;
            end
            CLS_OP: begin
                push_entry.kind = KIND_OP;
                push_entry.arg  = {2'b00, op_reg};
            end
            default: begin
                push_entry.kind = KIND_LPAREN;
            end
        endcase

        top_res = entry_to_result(top);

        num_res       = '0;
        num_res.kind  = OUT_NUMBER;
        num_res.value = value_reg;
        num_res.last  = 1'b1;

        mark_res      = '0;
        mark_res.kind = OUT_END;
        if (ovf_reg) begin
            mark_res.status = ST_OVERFLOW;
        end else if (sts.has_lparen) begin
            mark_res.status = ST_MISMATCH;
        end else begin
            mark_res.status = ST_OK;
        end
    end

    always_comb begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        ovf_next        = ovf_reg;
        cmd             = '0;
        cmd.data        = push_entry;
        out_valid       = 1'b0;
        out_data        = pend_reg;
        out_data.last   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (cls_reg)
                    CLS_NUMBER: begin
                        if (out_ready) begin
                            out_valid  = 1'b1;
                            out_data   = num_res;
                            state_next = S_IDLE;
                        end
                    end
                    CLS_FUNC, CLS_LPAREN: begin
                        if (sts.full) begin
                            ovf_next = 1'b1;
                        end else begin
                            cmd.push = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    CLS_OP: begin
                        if (sts.empty) begin
                            cmd.push   = 1'b1;
                            state_next = S_IDLE;
                        end else begin
                            cmd.rd     = 1'b1;
                            state_next = S_OP;
                        end
                    end
                    CLS_RPAREN: begin
                        if (sts.empty) begin
                            state_next = S_IDLE;
                        end else begin
                            cmd.rd     = 1'b1;
                            state_next = S_RP;
                        end
                    end
                    CLS_END: begin
                        if (sts.empty || sts.has_lparen) begin
                            state_next = S_MARK;
                        end else begin
                            cmd.rd     = 1'b1;
                            state_next = S_END;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_OP: begin
                if (take) begin
                    if (adv) begin
                        out_valid       = pend_valid_reg;
                        pend_next       = top_res;
                        pend_valid_next = 1'b1;
                        cmd.pop         = 1'b1;
                        if (sts.one) begin
                            state_next = S_PUSH;
                        end else begin
                            cmd.rd = 1'b1;
                        end
                    end
                end else begin
                    if (sts.full) begin
                        ovf_next = 1'b1;
                    end else begin
                        cmd.push = 1'b1;
                    end
                    state_next = S_FLUSH;
                end
            end
            S_PUSH: begin
                cmd.push   = 1'b1;
                state_next = S_FLUSH;
            end
            S_RP: begin
                if (top.kind == KIND_LPAREN) begin
                    cmd.pop = 1'b1;
                    if (sts.one) begin
                        state_next = S_FLUSH;
                    end else begin
                        cmd.rd     = 1'b1;
                        state_next = S_RPF;
                    end
                end else if (adv) begin
                    out_valid       = pend_valid_reg;
                    pend_next       = top_res;
                    pend_valid_next = 1'b1;
                    cmd.pop         = 1'b1;
                    if (sts.one) begin
                        state_next = S_FLUSH;
                    end else begin
                        cmd.rd = 1'b1;
                    end
                end
            end
            S_RPF: begin
                if (top.kind == KIND_FUNC) begin
                    if (adv) begin
                        out_valid       = pend_valid_reg;
                        pend_next       = top_res;
                        pend_valid_next = 1'b1;
                        cmd.pop         = 1'b1;
                        state_next      = S_FLUSH;
                    end
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_END: begin
                if (adv) begin
                    out_valid       = pend_valid_reg;
                    pend_next       = top_res;
                    pend_valid_next = 1'b1;
                    cmd.pop         = 1'b1;
                    if (sts.one) begin
                        state_next = S_MARK;
                    end else begin
                        cmd.rd = 1'b1;
                    end
                end
            end
            S_MARK: begin
                if (adv) begin
                    out_valid       = pend_valid_reg;
                    pend_next       = mark_res;
                    pend_valid_next = 1'b1;
                    cmd.clear       = 1'b1;
                    ovf_next        = 1'b0;
                    state_next      = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_ready) begin
                    out_valid       = 1'b1;
                    out_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            ovf_reg        <= ovf_next;
        end
    end

    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> out_ready) else $error("result sent with no free slot");
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg) else $error("held result left at idle");
    a_mark_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (sts.empty && !ovf_reg)) else $error("end did not clear state");

endmodule

// File: rtl/core/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter: stream ports and output register.
//
// Converts a stream of classified tokens to postfix order with an operator
// stack (shunting yard). One token is taken at a time: s_tready is high only
// while the sequencer is idle. An operator, ')' or end token examines and
// pops stack entries one at a time, then pushes the operator or sends the
// end marker, and finally releases the last held result with tlast set. The
// single-port operator stack memory delivers one entry per cycle through its
// registered read port while the held result can leave. Back-pressure on
// m_tready stalls the sequencer once the output register is full. There is
// no clearing pass after reset: the stack memory is never read above its
// fill count. A function, operator or '(' that finds the stack full is
// dropped and reported as overflow on the next end marker; overflow outranks
// an unmatched '(' in that status. With an unmatched '(' only the end marker
// is sent. A ')' without a match flushes the stack and is otherwise ignored.
// Token classes 6 and 7 are dropped.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Token input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op_code[2:0], func_id[7:3], number_value[71:8]
    input  logic [2:0]  s_tuser,   // token_class[2:0]
    // Postfix output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // out_op[2:0], out_func[7:3], out_value[71:8],
                                   // status[73:72], zero[79:74]
    output logic [1:0]  m_tuser,   // out_kind[1:0]
    output logic        m_tlast    // out_last
);
    import i2p_pkg::*;

    stack_cmd_t stk_cmd;
    stack_sts_t stk_sts;
    entry_t     stk_top;

    logic       res_valid;
    result_t    res_data;
    logic       res_ready;

    logic       m_valid_reg, m_valid_next;
    result_t    m_data_reg;

    i2p_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .sts     (stk_sts),
        .top     (stk_top)
    );

    i2p_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_class   (s_tuser),
        .s_op      (s_tdata[2:0]),
        .s_func    (s_tdata[7:3]),
        .s_value   (s_tdata[71:8]),
        .cmd       (stk_cmd),
        .sts       (stk_sts),
        .top       (stk_top),
        .out_valid (res_valid),
        .out_data  (res_data),
        .out_ready (res_ready)
    );

    // Output register: take a new item when empty or when the current one leaves
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the payload until a new item is loaded
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.kind;
    assign m_tlast  = m_data_reg.last;
    assign m_tdata  = {6'b000000, m_data_reg.status, m_data_reg.value,
                       m_data_reg.func, m_data_reg.op};

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the infix-to-postfix converter stream block.
`timescale 1ns / 100ps

module testbench;
    import i2p_pkg::*;

    localparam int STACK_DEPTH  = 32;
    localparam int ITEM_COUNT   = 270;
    localparam int STALL_LIMIT  = 3000;  // cycles with no item moving on either side
    localparam int TAIL_CYCLES  = 100;   // settle time after the last expected result

    // One token as it travels on the input side
    typedef struct packed {
        logic [2:0]  cls;
        logic [2:0]  op;
        logic [4:0]  fn;
        logic [63:0] val;
    } token_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;  // op_code[2:0], func_id[7:3], number_value[71:8]
    logic [2:0]  s_tuser  = '0;  // token_class[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;        // out_op[2:0], out_func[7:3], out_value[71:8],
                                 // status[73:72], zero[79:74]
    logic [1:0]  m_tuser;        // out_kind[1:0]
    logic        m_tlast;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Tokens waiting to be driven, and postfix results waiting to come out
    token_t  token_q[$];
    result_t postfix_q[$];
    int      counted_items = 0;
    int      mismatches    = 0;

    // Shadow of the operator stack
    entry_t  op_stack[STACK_DEPTH];
    int      stack_fill = 0;
    bit      overflowed = 1'b0;
    int      emitted;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Queue one token; classes 6 and 7 are ignored by the block and not counted
    function automatic void send(input logic [2:0] cls, input logic [2:0] op,
                                 input logic [4:0] fn, input logic [63:0] val);
        token_t t;
        t.cls = cls;
        t.op  = op;
        t.fn  = fn;
        t.val = val;
        token_q = {token_q, t};
        if (cls <= CLS_END) counted_items++;
    endfunction

    // Mostly short gaps, a few long ones; none at all while calm
    function automatic int draw_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int bind_strength(input logic [2:0] op);
        case (op)
            OP_PLUS, OP_MINUS:   return 1;
            OP_TIMES, OP_DIVIDE: return 2;
            OP_POWER:            return 3;
            default:             return 0;
        endcase
    endfunction

    function automatic void expect_result(input logic [1:0] kind, input logic [2:0] op,
                                          input logic [4:0] fn, input logic [63:0] val,
                                          input logic [1:0] st);
        result_t r;
        r        = '0;
        r.kind   = kind;
        r.op     = op;
        r.func   = fn;
        r.value  = val;
        r.status = st;
        postfix_q = {postfix_q, r};
        emitted++;
    endfunction

    function automatic void expect_entry(input entry_t e);
        if (e.kind == KIND_FUNC) expect_result(OUT_FUNC, 3'd0, e.arg, 64'd0, ST_OK);
        else expect_result(OUT_OP, e.arg[2:0], 5'd0, 64'd0, ST_OK);
    endfunction

    // Push onto the shadow stack; a full stack drops the entry and flags overflow
    function automatic void stack_push(input logic [1:0] kind, input logic [4:0] arg);
        if (stack_fill >= STACK_DEPTH) begin
            overflowed = 1'b1;
        end else begin
            op_stack[stack_fill] = {kind, arg};
            stack_fill++;
        end
    endfunction

    // Work out the postfix results that one accepted token causes
    function automatic void convert_token(input token_t t);
        entry_t     top;
        int         p;
        int         tp;
        bit         take;
        bit         unmatched;
        logic [1:0] st;
        result_t    tail;
        emitted = 0;
        case (t.cls)
            CLS_NUMBER: expect_result(OUT_NUMBER, 3'd0, 5'd0, t.val, ST_OK);
            CLS_FUNC:   stack_push(KIND_FUNC, t.fn);
            CLS_LPAREN: stack_push(KIND_LPAREN, 5'd0);
            CLS_OP: begin
                // Pop functions and operators that bind at least as tightly;
                // power is right-associative, so equal power stays put
                p    = bind_strength(t.op);
                take = 1'b1;
                while (take && stack_fill > 0) begin
                    top = op_stack[stack_fill - 1];
                    if (top.kind == KIND_FUNC) begin
                        take = 1'b1;
                    end else if (top.kind == KIND_OP) begin
                        tp   = bind_strength(top.arg[2:0]);
                        take = (tp > p) || (tp == p && t.op != OP_POWER);
                    end else begin
                        take = 1'b0;
                    end
                    if (take) begin
                        expect_entry(top);
                        stack_fill--;
                    end
                end
                stack_push(KIND_OP, {2'b00, t.op});
            end
            CLS_RPAREN: begin
                // Pop down to the matching '(', drop it, then pop one function
                while (stack_fill > 0 &&
                       op_stack[stack_fill - 1].kind != KIND_LPAREN) begin
                    expect_entry(op_stack[stack_fill - 1]);
                    stack_fill--;
                end
                if (stack_fill > 0) begin
                    stack_fill--;
                    if (stack_fill > 0 && op_stack[stack_fill - 1].kind == KIND_FUNC) begin
                        expect_entry(op_stack[stack_fill - 1]);
                        stack_fill--;
                    end
                end
            end
            CLS_END: begin
                // An open '(' suppresses the flush; overflow outranks it in status
                unmatched = 1'b0;
                for (int i = 0; i < stack_fill; i++)
                    if (op_stack[i].kind == KIND_LPAREN) unmatched = 1'b1;
                if (!unmatched) begin
                    while (stack_fill > 0) begin
                        expect_entry(op_stack[stack_fill - 1]);
                        stack_fill--;
                    end
                end
                st = overflowed ? ST_OVERFLOW : (unmatched ? ST_MISMATCH : ST_OK);
                expect_result(OUT_END, 3'd0, 5'd0, 64'd0, st);
                stack_fill = 0;
                overflowed = 1'b0;
            end
            default: ;
        endcase
        if (emitted > 0) begin
            tail      = postfix_q[postfix_q.size() - 1];
            tail.last = 1'b1;
            postfix_q[postfix_q.size() - 1] = tail;
        end
    endfunction

    // Driver: hold an item until accepted, then idle for a random gap
    token_t bus_tok;
    int     drv_gap  = 0;
    bit     drv_calm = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                convert_token(bus_tok);
                drv_gap = draw_gap(drv_calm);
                if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
            end
            if (drv_gap > 0) begin
                drv_gap--;
                s_tvalid <= 1'b0;
            end else if (token_q.size() > 0) begin
                bus_tok = token_q.pop_front();
                s_tdata  <= {bus_tok.val, bus_tok.fn, bus_tok.op};
                s_tuser  <= bus_tok.cls;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest expectation, then stall at random
    int mon_stall = 0;
    bit mon_calm  = 1'b0;

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got        = '0;
                got.kind   = m_tuser;
                got.op     = m_tdata[2:0];
                got.func   = m_tdata[7:3];
                got.value  = m_tdata[71:8];
                got.status = m_tdata[73:72];
                got.last   = m_tlast;
                if (postfix_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result kind=%0d op=%0d func=%0d",
                                 $time, got.kind, got.op, got.func,
                                 " value=%h last=%0d status=%0d",
                                 got.value, got.last, got.status);
                end else begin
                    want = postfix_q.pop_front();
                    if (got.kind !== want.kind || got.op !== want.op || got.func !== want.func ||
                        got.value !== want.value || got.last !== want.last ||
                        got.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected kind=%0d op=%0d func=%0d",
                                     $time, want.kind, want.op, want.func,
                                     " value=%h last=%0d status=%0d",
                                     want.value, want.last, want.status);
                            $display("%0t:   actual kind=%0d op=%0d func=%0d",
                                     $time, got.kind, got.op, got.func,
                                     " value=%h last=%0d status=%0d",
                                     got.value, got.last, got.status);
                        end
                    end
                end
                mon_stall = draw_gap(mon_calm);
                if ($urandom_range(0, 39) == 0) mon_calm = !mon_calm;
            end
            if (mon_stall > 0) begin
                mon_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int deep_runs;
        int pick;
        int depth;
        int len;
        int target;
        bit operand;
        bit done;

        // Directed: f31(0 + max) ^ a ^ b * c - d / e, with extreme field values
        send(CLS_FUNC,   3'd7, 5'd31, '1);
        send(CLS_LPAREN, 3'd0, 5'd0, 64'd0);
        send(CLS_NUMBER, 3'd0, 5'd0, 64'd0);
        send(CLS_OP,     OP_PLUS, 5'd31, '1);
        send(CLS_NUMBER, 3'd7, 5'd31, '1);
        send(CLS_RPAREN, 3'd7, 5'd31, '1);
        send(CLS_OP,     OP_POWER, 5'd0, 64'd0);
        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
        send(CLS_OP,     OP_POWER, 5'd0, 64'd0);
        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
        send(CLS_OP,     OP_TIMES, 5'd0, 64'd0);
        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
        send(CLS_OP,     OP_MINUS, 5'd0, 64'd0);
        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
        send(CLS_OP,     OP_DIVIDE, 5'd0, 64'd0);
        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
        send(CLS_END,    3'd7, 5'd31, '1);
        // Open '(' at end: only the marker, flagged as mismatched
        send(CLS_LPAREN, 3'd0, 5'd0, 64'd0);
        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
        send(CLS_END,    3'd0, 5'd0, 64'd0);
        // Stray ')' flushes the stack; ignored classes sit in between
        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
        send(CLS_OP,     OP_MINUS, 5'd0, 64'd0);
        send(3'd6,       3'd0, 5'd0, rnd64());
        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
        send(3'd7,       3'd7, 5'd31, '1);
        send(CLS_RPAREN, 3'd0, 5'd0, 64'd0);
        send(CLS_END,    3'd0, 5'd0, 64'd0);
        deep_runs  = 0;

        // Random: mostly well-formed expressions, some noise, some stack overflow
        while (counted_items < ITEM_COUNT) begin
            pick = (deep_runs < 2) ? 19 : $urandom_range(0, 19);
            if (pick < 15) begin
                depth   = 0;
                len     = 0;
                operand = 1'b1;
                done    = 1'b0;
                target  = $urandom_range(1, 14);
                while (!done) begin
                    if (operand) begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6 || depth >= 6) begin
                            send(CLS_NUMBER, 3'($urandom_range(0, 7)), 5'($urandom), rnd64());
                            operand = 1'b0;
                        end else begin
                            if (pick < 8)
                                send(CLS_FUNC, 3'($urandom_range(0, 7)), 5'($urandom), rnd64());
                            send(CLS_LPAREN, 3'($urandom_range(0, 7)), 5'($urandom), rnd64());
                            depth++;
                        end
                    end else if (len >= target && depth == 0) begin
                        done = 1'b1;
                    end else if (depth > 0 && (len >= target || $urandom_range(0, 3) == 0)) begin
                        send(CLS_RPAREN, 3'($urandom_range(0, 7)), 5'($urandom), rnd64());
                        depth--;
                    end else begin
                        // Unknown op codes show up now and then
                        send(CLS_OP, ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                                 : 3'($urandom_range(0, 4)),
                             5'($urandom), rnd64());
                        operand = 1'b1;
                    end
                    len++;
                end
                send(CLS_END, 3'($urandom_range(0, 7)), 5'($urandom), rnd64());
            end else if (pick < 18) begin
                // Noise: any class, any fields, left open half the time
                repeat ($urandom_range(1, 8))
                    send(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 5'($urandom), rnd64());
                if ($urandom_range(0, 1)) send(CLS_END, 3'd0, 5'($urandom), rnd64());
            end else begin
                // Overflow: a long power chain, or deep nesting of '(' and functions
                if (deep_runs[0] == 1'b0 || (deep_runs >= 2 && $urandom_range(0, 1))) begin
                    send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
                    repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 6)) begin
                        send(CLS_OP, OP_POWER, 5'($urandom), rnd64());
                        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
                    end
                    if ($urandom_range(0, 1)) begin
                        send(CLS_OP, OP_PLUS, 5'($urandom), rnd64());
                        send(CLS_NUMBER, 3'd0, 5'd0, rnd64());
                    end
                end else begin
                    repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 6))
                        send($urandom_range(0, 1) ? CLS_FUNC : CLS_LPAREN,
                             3'($urandom_range(0, 7)), 5'($urandom), rnd64());
                end
                send(CLS_END, 3'd0, 5'd0, rnd64());
                deep_runs++;
            end
        end

        // Release reset, then drain both sides
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (token_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (postfix_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && postfix_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
